/* hw/rtl/i2cms_pkg.sv */
package i2cms_pkg;

    // action codes carried by a command item
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // sequence kinds held while busy
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // step numbers that mark phase boundaries
    localparam logic [4:0] STEP_FIRST     = 5'd1;
    localparam logic [4:0] STEP_WR_LAST   = 5'd15;
    localparam logic [4:0] STEP_WR_DATA   = 5'd14;
    localparam logic [4:0] STEP_WR_ACK    = 5'd16;
    localparam logic [4:0] STEP_RD_SHIFT  = 5'd7;
    localparam logic [4:0] STEP_RD_ACKBIT = 5'd8;
    localparam logic [4:0] STEP_RD_ACKHI  = 5'd9;
    localparam logic [2:0] BIT_MSB        = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_received;
        logic [7:0] rx_byte;
        logic       rejected;
    } res_item_t;

endpackage

/* hw/rtl/i2cms_in_stage.sv */
module i2cms_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  i2cms_pkg::cmd_item_t  cmd,
    input  logic                  advance,
    output logic                  item_valid,
    output i2cms_pkg::cmd_item_t  item
);

    logic                 valid_reg;
    logic                 valid_next;
    i2cms_pkg::cmd_item_t item_reg;

    // hold while the stored item cannot move on
    assign cmd_stall  = valid_reg && !advance;
    assign valid_next = cmd_stall ? valid_reg : cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            item_reg <= cmd;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/i2cms_core.sv */
module i2cms_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  i2cms_pkg::cmd_item_t  item,
    output logic                  advance,
    output logic                  res_valid,
    input  logic                  res_stall,
    output i2cms_pkg::res_item_t  res
);

    logic [2:0] op_reg,    op_next;
    logic [4:0] step_reg,  step_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg,   scl_next;
    logic       sda_reg,   sda_next;
    logic       drive_reg, drive_next;
    logic       ack_reg,   ack_next;
    logic [7:0] rx_reg,    rx_next;
    logic       nack_reg,  nack_next;
    logic       res_valid_reg;
    i2cms_pkg::res_item_t res_reg, res_next;

    logic       fire;
    logic       busy;
    logic       done;
    logic       rej;
    logic [4:0] s;
    logic [2:0] bit_idx;

    assign advance = !res_valid_reg || !res_stall;
    assign fire    = item_valid && advance;
    assign busy    = (op_reg != i2cms_pkg::OP_IDLE);
    assign s       = step_reg + 5'd1;
    assign bit_idx = i2cms_pkg::BIT_MSB - s[3:1];

    always_comb
    begin
        op_next    = op_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        nack_next  = nack_reg;
        done       = 1'b0;
        rej        = 1'b0;

        if (item.action == i2cms_pkg::ACT_TICK)
        begin
            if (busy)
            begin
                step_next = s;
                unique case (op_reg)
                    i2cms_pkg::OP_START:
                    begin
                        if (s == i2cms_pkg::STEP_FIRST)
                        begin
                            sda_next = 1'b0;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    end
                    i2cms_pkg::OP_STOP:
                    begin
                        if (s == i2cms_pkg::STEP_FIRST)
                        begin
                            sda_next = 1'b1;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    i2cms_pkg::OP_WRITE:
                    begin
                        priority if (s <= i2cms_pkg::STEP_WR_LAST && s[0])
                        begin
                            scl_next = 1'b1;
                        end
                        else if (s <= i2cms_pkg::STEP_WR_DATA)
                        begin
                            scl_next = 1'b0;
                            sda_next = shift_reg[bit_idx];
                        end
                        else if (s == i2cms_pkg::STEP_WR_ACK)
                        begin
                            drive_next = 1'b0;
                            scl_next   = 1'b1;
                        end
                        else
                        begin
                            ack_next   = !item.sda_in;
                            scl_next   = 1'b0;
                            drive_next = 1'b1;
                            done       = 1'b1;
                        end
                    end
                    i2cms_pkg::OP_READ:
                    begin
                        if (s <= i2cms_pkg::STEP_RD_ACKBIT)
                        begin
                            shift_next = {shift_reg[6:0], item.sda_in};
                        end
                        priority if (s <= i2cms_pkg::STEP_RD_SHIFT)
                        begin
                            scl_next = 1'b1;
                        end
                        else if (s == i2cms_pkg::STEP_RD_ACKBIT)
                        begin
                            scl_next   = 1'b0;
                            drive_next = 1'b1;
                            sda_next   = nack_reg;
                        end
                        else if (s == i2cms_pkg::STEP_RD_ACKHI)
                        begin
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            rx_next  = shift_reg;
                            done     = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (done)
                begin
                    op_next   = i2cms_pkg::OP_IDLE;
                    step_next = 5'd0;
                end
            end
        end
        else if (item.action <= i2cms_pkg::ACT_READ)
        begin
            if (busy)
            begin
                rej = 1'b1;
            end
            else
            begin
                op_next   = item.action;
                step_next = 5'd0;
                unique case (item.action)
                    i2cms_pkg::ACT_START:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        drive_next = 1'b1;
                    end
                    i2cms_pkg::ACT_STOP:
                    begin
                        sda_next   = 1'b0;
                        scl_next   = 1'b1;
                        drive_next = 1'b1;
                    end
                    i2cms_pkg::ACT_WRITE:
                    begin
                        shift_next = item.tx_byte;
                        drive_next = 1'b1;
                        sda_next   = item.tx_byte[7];
                    end
                    default:
                    begin
                        shift_next = 8'd0;
                        nack_next  = item.send_nack;
                        drive_next = 1'b0;
                        scl_next   = 1'b1;
                    end
                endcase
            end
        end

        res_next.scl_out      = scl_next;
        res_next.sda_out      = drive_next ? sda_next : 1'b1;
        res_next.sda_drive    = drive_next;
        res_next.busy_res     = (op_next != i2cms_pkg::OP_IDLE);
        res_next.done_res     = done;
        res_next.ack_received = ack_next;
        res_next.rx_byte      = rx_next;
        res_next.rejected     = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= i2cms_pkg::OP_IDLE;
            step_reg      <= 5'd0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
            ack_reg       <= 1'b0;
            rx_reg        <= 8'd0;
            nack_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                op_reg    <= op_next;
                step_reg  <= step_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                drive_reg <= drive_next;
                ack_reg   <= ack_next;
                rx_reg    <= rx_next;
                nack_reg  <= nack_next;
            end
            if (advance)
            begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hw/rtl/i2c_master_bit_sequencer.sv */
// a result item is registered in the result register after its command item has
// passed the input register; throughput: one item per cycle while no result is
// stalled, set by the single state update between the two registers
// reset: asynchronous, active low; bus idle with scl and sda driven high, no
// sequence in progress, no items held in either register
module i2c_master_bit_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  i2cms_pkg::cmd_item_t  cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output i2cms_pkg::res_item_t  res
);

    // stored command item handed from the input register to the core
    logic                 item_valid;
    i2cms_pkg::cmd_item_t item;

    // high when the core can take the stored item this cycle, i.e. the
    // result register is empty or its item is being taken
    logic                 advance;

    // input register: takes a new item when empty or when the stored one moves on,
    // so a waiting result never stops the input side for more than it must
    i2cms_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // sequencer state and result register: one tick or command per cycle while
    // no result stalls; pin levels, ack and received byte settle in that update
    i2cms_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

/* hw/rtl/i2cms_checker.sv */
module i2cms_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_stall,
    input i2cms_pkg::cmd_item_t  cmd,
    input logic                  res_valid,
    input logic                  res_stall,
    input i2cms_pkg::res_item_t  res
);

    // a finished sequence leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done reported while still busy");

    // a released line reads as pulled high
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.sda_drive |-> res.sda_out)
        else $error("released sda not high");

    // a rejected command only happens during a sequence
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.rejected |-> res.busy_res && !res.done_res)
        else $error("rejected while idle");

    // a stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // a stalled command item holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("stalled command changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (.*);
